FILE: rtl/core/pgtp_pkg.sv
// Shared types and codes of the priority guarded transition picker.
`default_nettype none
package pgtp_pkg;

   // request operation codes
   localparam logic [2:0] OP_WR_RANGE = 3'd0;
   localparam logic [2:0] OP_WR_LIST  = 3'd1;
   localparam logic [2:0] OP_WR_COND  = 3'd2;
   localparam logic [2:0] OP_WR_PARAM = 3'd3;
   localparam logic [2:0] OP_EVAL     = 3'd4;

   // guard compare codes
   localparam logic [2:0] CMP_ALWAYS = 3'd0;
   localparam logic [2:0] CMP_GT     = 3'd1;
   localparam logic [2:0] CMP_GE     = 3'd2;
   localparam logic [2:0] CMP_LT     = 3'd3;
   localparam logic [2:0] CMP_LE     = 3'd4;
   localparam logic [2:0] CMP_EQ     = 3'd5;
   localparam logic [2:0] CMP_NE     = 3'd6;

   // operand kinds
   localparam logic [1:0] KIND_SIGNED   = 2'd0;
   localparam logic [1:0] KIND_FLOAT    = 2'd1;
   localparam logic [1:0] KIND_UNSIGNED = 2'd2;
   localparam logic [1:0] KIND_BOOL     = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic accept;      // request taken, writes land now
      logic clear;       // parameter clearing pass step
      logic load_range;  // load list position and count
      logic index;       // form condition index from list entry
      logic eval;        // evaluate guard, advance walk
      logic load_rsp;    // move result to output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_eval;
      logic addr_ok;
      logic more;
      logic clear_done;
      logic rsp_busy;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/core/pgtp_ctrl.sv
// Sequencer for table writes and the transition walk.
`default_nettype none
module pgtp_ctrl
   import pgtp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type st,
   output cmd_type         cmd
);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_RANGE = 10'b0000000100,
      S_LOAD  = 10'b0000001000,
      S_LIST  = 10'b0000010000,
      S_INDEX = 10'b0000100000,
      S_COND  = 10'b0001000000,
      S_PARAM = 10'b0010000000,
      S_EVAL  = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (st.clear_done) state_in = S_IDLE;
            else cmd.clear = 1'b1;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = st.req_is_eval ? S_RANGE : S_RESP;
            end
         end
         S_RANGE: state_in = st.addr_ok ? S_LOAD : S_RESP;
         S_LOAD: begin
            cmd.load_range = 1'b1;
            state_in       = S_LIST;
         end
         S_LIST:  state_in = st.more ? S_INDEX : S_RESP;
         S_INDEX: begin
            cmd.index = 1'b1;
            state_in  = S_COND;
         end
         S_COND:  state_in = S_PARAM;
         S_PARAM: state_in = S_EVAL;
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_LIST;
         end
         S_RESP: begin
            if (!st.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/pgtp_datapath.sv
// Tables, guard comparator, best-candidate tracking and result register.
`default_nettype none
module pgtp_datapath
   import pgtp_pkg::*;
#(
   parameter int NUM_STATES      = 64,
   parameter int NUM_TRANSITIONS = 256,
   parameter int MAX_PROFILES    = 4,
   parameter int NUM_PARAMS      = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       st,
   input  wire logic [2:0]  req_op,
   input  wire logic [7:0]  req_table_address,
   input  wire logic [1:0]  req_profile,
   input  wire logic [2:0]  req_cmp_code,
   input  wire logic [1:0]  req_value_kind,
   input  wire logic        req_left_is_const,
   input  wire logic [31:0] req_left_operand,
   input  wire logic        req_right_is_const,
   input  wire logic [31:0] req_right_operand,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic [5:0]  req_dest_state,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_transitioned,
   output logic [5:0]       rsp_new_state
);

   localparam int COND_DEPTH = NUM_TRANSITIONS * MAX_PROFILES;
   localparam int SW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int TW  = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
   localparam int TCW = $clog2(NUM_TRANSITIONS + 1);
   localparam int CW  = (COND_DEPTH > 1) ? $clog2(COND_DEPTH) : 1;
   localparam int PW  = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int IW  = ((TW > 8) ? TW : 8) + 5;
   localparam logic [IW-1:0]   CD_W  = IW'(COND_DEPTH);
   localparam logic [TCW-1:0]  NT_C  = TCW'(NUM_TRANSITIONS);
   localparam logic [31:0]     NT_32 = 32'(NUM_TRANSITIONS);
   localparam logic [31:0]     NP_32 = 32'(NUM_PARAMS);
   localparam logic [PW:0]     NP_C  = (PW+1)'(NUM_PARAMS);

   typedef struct packed {
      logic [2:0]  cmp;
      logic [1:0]  kind;
      logic [7:0]  prio;
      logic [5:0]  dest;
      logic        lconst;
      logic [31:0] lbits;
      logic        rconst;
      logic [31:0] rbits;
   } cond_type;

   // memories
   logic [2*TCW-1:0] range_mem [NUM_STATES];
   logic [TW:0]      list_mem  [NUM_TRANSITIONS];
   cond_type         cond_mem  [COND_DEPTH];
   logic [31:0]      param_mem [NUM_PARAMS];

   logic [2*TCW-1:0] range_q;
   logic [TW:0]      list_q;
   cond_type         cond_q;
   logic [31:0]      par_l_q, par_r_q;

   // captured request
   logic [2:0] op_ff;
   logic [7:0] addr_ff;
   logic [1:0] prof_ff;
   logic [2:0] profile_count_ff;
   logic [PW:0] clr_ff;
   logic [TCW-1:0] pos_ff, cnt_ff;
   logic [CW-1:0]  idx_ff;
   logic           idx_ok_ff;
   logic           found_ff;
   logic [7:0]     best_prio_ff;
   logic [5:0]     best_dest_ff;
   logic           rsp_valid_ff;
   logic           rsp_tr_ff;
   logic [5:0]     rsp_ns_ff;

   // effective stride
   logic [2:0] stride;
   always_comb begin
      if (profile_count_ff == 3'd0) stride = 3'd1;
      else if (32'(profile_count_ff) > 32'(MAX_PROFILES)) stride = 3'(MAX_PROFILES);
      else stride = profile_count_ff;
   end

   // write-side condition index
   logic [IW-1:0] widx;
   assign widx = IW'(req_table_address) * IW'(stride) + IW'(req_profile);

   logic [TCW-1:0] sat_start, sat_count;
   assign sat_start = (req_left_operand > NT_32) ? NT_C : TCW'(req_left_operand);
   assign sat_count = (req_right_operand > NT_32) ? NT_C : TCW'(req_right_operand);

   logic wr_ok_range;
   assign wr_ok_range = (32'(req_table_address) < 32'(NUM_STATES));

   // table writes land when the request is accepted
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (req_op == OP_WR_RANGE && wr_ok_range)
            range_mem[SW'(req_table_address)] <= {sat_start, sat_count};
         if (req_op == OP_WR_LIST && 32'(req_table_address) < NT_32)
            list_mem[TW'(req_table_address)] <=
               {req_left_operand >= NT_32, TW'(req_left_operand)};
         if (req_op == OP_WR_COND && widx < CD_W)
            cond_mem[CW'(widx)] <= '{req_cmp_code, req_value_kind, req_priority_req,
                                     req_dest_state, req_left_is_const,
                                     req_left_operand, req_right_is_const,
                                     req_right_operand};
      end
      range_q <= range_mem[SW'(addr_ff)];
      list_q  <= list_mem[TW'(pos_ff)];
      cond_q  <= cond_mem[idx_ff];
   end

   // parameter store: clearing pass, writes, two registered reads
   always_ff @(posedge clock) begin
      if (cmd.clear)
         param_mem[PW'(clr_ff)] <= 32'd0;
      else if (cmd.accept && req_op == OP_WR_PARAM && 32'(req_table_address) < NP_32)
         param_mem[PW'(req_table_address)] <= req_left_operand;
      par_l_q <= param_mem[PW'(cond_q.lbits)];
      par_r_q <= param_mem[PW'(cond_q.rbits)];
   end

   // read-side condition index from the list entry
   logic [IW-1:0] ridx;
   assign ridx = IW'(list_q[TW-1:0]) * IW'(stride) + IW'(prof_ff);

   // resolve operands
   logic [31:0] a, b;
   assign a = cond_q.lconst ? cond_q.lbits : ((cond_q.lbits >= NP_32) ? 32'd0 : par_l_q);
   assign b = cond_q.rconst ? cond_q.rbits : ((cond_q.rbits >= NP_32) ? 32'd0 : par_r_q);

   // ordering per kind
   logic lt, gt, eq, unord;
   logic a_nan, b_nan, zeros, a_t, b_t;
   always_comb begin
      a_nan = (&a[30:23]) && (|a[22:0]);
      b_nan = (&b[30:23]) && (|b[22:0]);
      zeros = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      a_t   = |a;
      b_t   = |b;
      unord = 1'b0;
      case (cond_q.kind)
         KIND_SIGNED: begin
            lt = $signed(a) < $signed(b);
            gt = $signed(a) > $signed(b);
            eq = a == b;
         end
         KIND_FLOAT: begin
            unord = a_nan || b_nan;
            eq    = (a == b) || zeros;
            if (a[31] != b[31]) begin
               lt = a[31] && !zeros;
               gt = b[31] && !zeros;
            end else if (!a[31]) begin
               lt = a < b;
               gt = a > b;
            end else begin
               lt = a > b;
               gt = a < b;
            end
         end
         KIND_UNSIGNED: begin
            lt = a < b;
            gt = a > b;
            eq = a == b;
         end
         default: begin
            lt = !a_t && b_t;
            gt = a_t && !b_t;
            eq = a_t == b_t;
         end
      endcase
   end

   logic hold;
   always_comb begin
      if (cond_q.cmp == CMP_ALWAYS) hold = 1'b1;
      else if (unord) hold = (cond_q.cmp == CMP_NE);
      else begin
         case (cond_q.cmp)
            CMP_GT:  hold = gt;
            CMP_GE:  hold = gt || eq;
            CMP_LT:  hold = lt;
            CMP_LE:  hold = lt || eq;
            CMP_EQ:  hold = eq;
            CMP_NE:  hold = !eq;
            default: hold = 1'b0;
         endcase
      end
   end

   logic hit;
   assign hit = idx_ok_ff && hold && (!found_ff || cond_q.prio > best_prio_ff);

   // walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         profile_count_ff <= 3'd1;
         clr_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_en) profile_count_ff <= csr_write_data;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (cmd.accept) begin
         op_ff    <= req_op;
         addr_ff  <= req_table_address;
         prof_ff  <= req_profile;
         found_ff <= 1'b0;
      end
      if (cmd.load_range) begin
         pos_ff <= range_q[2*TCW-1:TCW];
         cnt_ff <= range_q[TCW-1:0];
      end
      if (cmd.index) begin
         idx_ff    <= CW'(ridx);
         idx_ok_ff <= !list_q[TW] && (ridx < CD_W);
      end
      if (cmd.eval) begin
         pos_ff <= pos_ff + 1'b1;
         cnt_ff <= cnt_ff - 1'b1;
         if (hit) begin
            found_ff     <= 1'b1;
            best_prio_ff <= cond_q.prio;
            best_dest_ff <= cond_q.dest;
         end
      end
      if (cmd.load_rsp) begin
         rsp_tr_ff <= (op_ff == OP_EVAL) && found_ff;
         if (op_ff != OP_EVAL) rsp_ns_ff <= 6'd0;
         else if (found_ff) rsp_ns_ff <= best_dest_ff;
         else rsp_ns_ff <= addr_ff[5:0];
      end
   end

   // status
   assign st.req_is_eval = (req_op == OP_EVAL);
   assign st.addr_ok     = (32'(addr_ff) < 32'(NUM_STATES));
   assign st.more        = (cnt_ff != '0) && (pos_ff < NT_C);
   assign st.clear_done  = (clr_ff == NP_C);
   assign st.rsp_busy    = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_transitioned = rsp_tr_ff;
   assign rsp_new_state    = rsp_ns_ff;

endmodule
`default_nettype wire

FILE: rtl/core/priority_guarded_transition_picker_top.sv
// Top level of the priority guarded transition picker.
// Requests are handled one at a time and each gives exactly one result. A table write
// (ops 0..3) or an unused op goes from acceptance straight to the result load, and an
// evaluate of a state at or past NUM_STATES passes only the range check before it. An
// evaluate of a listed state loads the range, then walks the list positions; each
// transition passes through a list read, a condition read and a parameter read before
// its guard is judged. A result held by rsp_stall delays the next result load until
// the stall ends, and the next request can be taken the cycle after the result load.
// After reset a clearing pass zeroes the parameter store, and no request is taken
// until that pass ends; csr writes are taken at any time.
`default_nettype none
module priority_guarded_transition_picker_top
   import pgtp_pkg::*;
#(
   parameter int NUM_STATES      = 64,
   parameter int NUM_TRANSITIONS = 256,
   parameter int MAX_PROFILES    = 4,
   parameter int NUM_PARAMS      = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_op,
   input  wire logic [7:0]  req_table_address,
   input  wire logic [1:0]  req_profile,
   input  wire logic [2:0]  req_cmp_code,
   input  wire logic [1:0]  req_value_kind,
   input  wire logic        req_left_is_const,
   input  wire logic [31:0] req_left_operand,
   input  wire logic        req_right_is_const,
   input  wire logic [31:0] req_right_operand,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic [5:0]  req_dest_state,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_transitioned,
   output logic [5:0]       rsp_new_state,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_write_data
);

   cmd_type    cmd;
   status_type st;

   // sequencer
   pgtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // tables and comparator
   pgtp_datapath #(
      .NUM_STATES      (NUM_STATES),
      .NUM_TRANSITIONS (NUM_TRANSITIONS),
      .MAX_PROFILES    (MAX_PROFILES),
      .NUM_PARAMS      (NUM_PARAMS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_op             (req_op),
      .req_table_address  (req_table_address),
      .req_profile        (req_profile),
      .req_cmp_code       (req_cmp_code),
      .req_value_kind     (req_value_kind),
      .req_left_is_const  (req_left_is_const),
      .req_left_operand   (req_left_operand),
      .req_right_is_const (req_right_is_const),
      .req_right_operand  (req_right_operand),
      .req_priority_req   (req_priority_req),
      .req_dest_state     (req_dest_state),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_transitioned   (rsp_transitioned),
      .rsp_new_state      (rsp_new_state)
   );

endmodule
`default_nettype wire
